/* rtl/tsa_pkg.sv */
package tsa_pkg;

  // Geometry of the slot store
  localparam int ARRAYS  = 4;
  localparam int SLOTS   = 32;
  localparam int ID_BITS = 32;

  localparam int ARR_W  = (ARRAYS > 1) ? $clog2(ARRAYS) : 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(ARRAYS + 1);
  localparam int ADDR_W = ((ARRAYS * SLOTS) > 1) ? $clog2(ARRAYS * SLOTS) : 1;

  // Widths of the request and result fields on the ports
  localparam int OP_W     = 2;
  localparam int TEX_W    = 32;
  localparam int STAT_W   = 2;
  localparam int OUT_AW   = 2;
  localparam int OUT_SW   = 5;
  localparam int OUT_CW   = 3;

  typedef logic [SLOTS-1:0]   mask_t;
  typedef logic [ID_BITS-1:0] id_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_NEW       = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } stat_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic decide;
    logic out_load;
  } tsa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
  } tsa_stat_t;

  // Index of the lowest set bit; the caller guarantees a non-zero mask.
  function automatic logic [SLOT_W-1:0] lowest_set(input mask_t m);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/tsa_ctrl.sv */
module tsa_ctrl
  import tsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_free,
  input  tsa_stat_t dp_stat,
  output tsa_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (dp_stat.scan_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
      end
      ST_OUT: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded into a busy output register");

  // A request is only taken between operations.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == ST_SCAN)
    else $error("accepted request did not start a scan");

  // The lookup result is settled before the decision cycle.
  a_decide_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> $past(cmd.scan) && $past(dp_stat.scan_done))
    else $error("decision without a finished scan");

endmodule

/* rtl/tsa_datapath.sv */
module tsa_datapath
  import tsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  tsa_cmd_t           cmd,
  output tsa_stat_t          dp_stat,
  input  logic [OP_W-1:0]    in_op,
  input  id_t                in_id,
  output logic [STAT_W-1:0]  res_status,
  output logic [ARR_W-1:0]   res_arr,
  output logic [SLOT_W-1:0]  res_slot,
  output logic [CNT_W-1:0]   open_count
);

  mask_t             free_masks [ARRAYS];
  logic [OP_W-1:0]   op_q;
  id_t               id_q;

  // Id store, one entry per slot, read one entry a cycle during a scan
  id_t               slot_ids [ARRAYS*SLOTS];
  id_t               rdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  // Scan position and pending compare
  logic [CNT_W-1:0]  scan_arr;
  logic [SLOT_W-1:0] scan_slot;
  logic              pv;
  logic [ARR_W-1:0]  pend_arr;
  logic [SLOT_W-1:0] pend_slot;
  logic              found;
  logic [ARR_W-1:0]  hit_arr;
  logic [SLOT_W-1:0] hit_slot;
  logic              issuing;
  logic              match;

  // Decision signals
  logic              sel_any;
  logic [ARR_W-1:0]  sel_arr;
  logic              can_open;
  logic [ARR_W-1:0]  new_arr;
  logic [SLOT_W-1:0] slot_pick;
  logic              do_insert;
  logic              do_open;
  logic              do_remove;
  logic [STAT_W-1:0] status_next;
  logic [ARR_W-1:0]  arr_next;
  logic [SLOT_W-1:0] slot_next;

  // Request payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q <= in_op;
      id_q <= in_id;
    end
  end

  // Read side of the scan: walk the slots of the open arrays in turn until a hit.
  assign issuing = cmd.scan && !found && (scan_arr != open_count);
  assign rd_en   = issuing;
  assign rd_addr = ADDR_W'(scan_arr * SLOTS + scan_slot);
  assign match   = pv && !free_masks[pend_arr][pend_slot] && (rdata == id_q);

  assign dp_stat.scan_done = found || ((scan_arr == open_count) && !pv);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv    <= 1'b0;
      found <= 1'b0;
    end else if (cmd.accept) begin
      pv    <= 1'b0;
      found <= 1'b0;
    end else if (cmd.scan) begin
      pv <= issuing;
      if (match && !found) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_arr  <= '0;
      scan_slot <= '0;
    end else if (issuing) begin
      pend_arr  <= ARR_W'(scan_arr);
      pend_slot <= scan_slot;
      if (scan_slot == SLOT_W'(SLOTS - 1)) begin
        scan_slot <= '0;
        scan_arr  <= scan_arr + CNT_W'(1);
      end else begin
        scan_slot <= scan_slot + SLOT_W'(1);
      end
    end
    if (cmd.scan && match && !found) begin
      hit_arr  <= pend_arr;
      hit_slot <= pend_slot;
    end
  end

  // Id store with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_ids[wr_addr] <= id_q;
    end
    if (rd_en) begin
      rdata <= slot_ids[rd_addr];
    end
  end

  // First open array that still has a free slot.
  always_comb begin
    sel_any = 1'b0;
    sel_arr = '0;
    for (int a = ARRAYS - 1; a >= 0; a--) begin
      if ((CNT_W'(a) < open_count) && (free_masks[a] != '0)) begin
        sel_any = 1'b1;
        sel_arr = ARR_W'(a);
      end
    end
  end

  assign can_open  = open_count < CNT_W'(ARRAYS);
  assign new_arr   = sel_any ? sel_arr : ARR_W'(open_count);
  assign slot_pick = lowest_set(free_masks[new_arr]);

  // Outcome of the request.
  always_comb begin
    do_insert   = 1'b0;
    do_open     = 1'b0;
    do_remove   = 1'b0;
    status_next = STAT_NOT_FOUND;
    arr_next    = '0;
    slot_next   = '0;
    if (op_q == OP_INSERT) begin
      if (found) begin
        status_next = STAT_FOUND;
        arr_next    = hit_arr;
        slot_next   = hit_slot;
      end else if (sel_any || can_open) begin
        do_insert   = 1'b1;
        do_open     = !sel_any;
        status_next = STAT_NEW;
        arr_next    = new_arr;
        slot_next   = slot_pick;
      end else begin
        status_next = STAT_FULL;
      end
    end else if (found) begin
      do_remove   = (op_q == OP_REMOVE);
      status_next = STAT_FOUND;
      arr_next    = hit_arr;
      slot_next   = hit_slot;
    end
  end

  assign wr_en   = cmd.decide && do_insert;
  assign wr_addr = ADDR_W'(new_arr * SLOTS + slot_pick);

  // Free masks and the open array count.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < ARRAYS; a++) begin
        free_masks[a] <= '1;
      end
      open_count <= CNT_W'(1);
    end else if (cmd.decide) begin
      if (do_insert) begin
        free_masks[new_arr][slot_pick] <= 1'b0;
      end
      if (do_remove) begin
        free_masks[hit_arr][hit_slot] <= 1'b1;
      end
      if (do_open) begin
        open_count <= open_count + CNT_W'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_status <= status_next;
      res_arr    <= arr_next;
      res_slot   <= slot_next;
    end
  end

  // The open count stays within the number of arrays.
  a_open_range: assert property (@(posedge clk) disable iff (rst)
    (open_count >= CNT_W'(1)) && (open_count <= CNT_W'(ARRAYS)))
    else $error("open array count out of range");

  // A newly placed id occupies its slot afterwards.
  a_insert_taken: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && do_insert |=> !free_masks[$past(new_arr)][$past(slot_pick)])
    else $error("inserted slot still marked free");

  // The open count only moves on a decision.
  a_open_on_decide: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (open_count != $past(open_count)) |-> $past(cmd.decide))
    else $error("open array count changed outside a decision");

endmodule

/* rtl/texture_slot_allocator_top.sv */
// Time from request to result grows with arrays_open when the id is absent, or
// with the scan position of the hit; the id store is read one slot a cycle
// through its single read port.
// One request at a time: the next can be taken in the cycle after a result is loaded,
// and a finished result waits in the output register while the next one runs.
// Reset opens one array with all slots free; the id store is not cleared.
module texture_slot_allocator_top
  import tsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] tex_id
  input  logic [1:0]  s_tuser,  // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [1:0] array_index, [6:2] slot_index,
                                // [9:7] arrays_open, [15:10] zero
  output logic [1:0]  m_tuser   // [1:0] status
);

  tsa_cmd_t          cmd;
  tsa_stat_t         dp_stat;
  logic              out_free;
  id_t               in_id;
  logic [STAT_W-1:0] res_status;
  logic [ARR_W-1:0]  res_arr;
  logic [SLOT_W-1:0] res_slot;
  logic [CNT_W-1:0]  open_count;

  assign in_id    = ID_BITS'(s_tdata[TEX_W-1:0]);
  assign out_free = !m_tvalid || m_tready;

  tsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .dp_stat  (dp_stat),
    .cmd      (cmd)
  );

  tsa_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .dp_stat    (dp_stat),
    .in_op      (s_tuser),
    .in_id      (in_id),
    .res_status (res_status),
    .res_arr    (res_arr),
    .res_slot   (res_slot),
    .open_count (open_count)
  );

  // Output register for the result of each request.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= res_status;
      m_tdata <= {6'd0, OUT_CW'(open_count), OUT_SW'(res_slot), OUT_AW'(res_arr)};
    end
  end

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import tsa_pkg::*;

  // The fourth operation code, which the block treats as a look-up
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 150;

  // One expected result, in the order of the result fields
  typedef struct packed {
    stat_code_t status;
    logic [1:0] arr;
    logic [4:0] slot;
    logic [2:0] opened;
  } alloc_result_t;

  typedef struct {
    logic [1:0]    op;
    id_t           id;
    bit            typed;
    alloc_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  texture_slot_allocator_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Mirror of the allocator state
  mask_t free_map [ARRAYS];
  int    arrays_in_use;
  id_t   slot_tex [ARRAYS*SLOTS];
  id_t   recent_tex [64];
  int    recent_wr;

  alloc_result_t pending_results [$];
  alloc_result_t head;

  int mismatches;
  int requests_sent;
  int results_checked;
  int full_replies;
  int idle_cycles;
  int stall_left;
  bit gaps_on;
  bit stalls_on;
  bit quiet;

  // Directed requests; typed rows carry results that follow at a glance.
  dir_row_t dir_rows [18] = '{
    '{OP_LOOKUP, 32'h0000_0000, 1, '{STAT_NOT_FOUND, 2'd0, 5'd0, 3'd1}},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1, '{STAT_NOT_FOUND, 2'd0, 5'd0, 3'd1}},
    '{OP_INSERT, 32'h0000_0000, 1, '{STAT_NEW,       2'd0, 5'd0, 3'd1}},
    '{OP_INSERT, 32'hFFFF_FFFF, 1, '{STAT_NEW,       2'd0, 5'd1, 3'd1}},
    '{OP_INSERT, 32'h0000_0000, 1, '{STAT_FOUND,     2'd0, 5'd0, 3'd1}},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 1, '{STAT_FOUND,     2'd0, 5'd1, 3'd1}},
    '{OP_SPARE,  32'hFFFF_FFFF, 1, '{STAT_FOUND,     2'd0, 5'd1, 3'd1}},
    '{OP_SPARE,  32'h1234_5678, 1, '{STAT_NOT_FOUND, 2'd0, 5'd0, 3'd1}},
    '{OP_REMOVE, 32'h0000_0000, 1, '{STAT_FOUND,     2'd0, 5'd0, 3'd1}},
    '{OP_LOOKUP, 32'h0000_0000, 1, '{STAT_NOT_FOUND, 2'd0, 5'd0, 3'd1}},
    '{OP_INSERT, 32'h8000_0000, 1, '{STAT_NEW,       2'd0, 5'd0, 3'd1}},
    '{OP_REMOVE, 32'h0000_0000, 1, '{STAT_NOT_FOUND, 2'd0, 5'd0, 3'd1}},
    '{OP_INSERT, 32'h0000_0001, 0, '0},
    '{OP_INSERT, 32'h7FFF_FFFF, 0, '0},
    '{OP_LOOKUP, 32'h0000_0001, 0, '0},
    '{OP_REMOVE, 32'h8000_0000, 1, '{STAT_FOUND,     2'd0, 5'd0, 3'd1}},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1, '{STAT_FOUND,     2'd0, 5'd1, 3'd1}},
    '{OP_INSERT, 32'hA5A5_A5A5, 0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Searches the occupied slots of the open arrays for an id.
  function automatic bit locate(input id_t id, output int hit_arr, output int hit_slot);
    int a;
    int s;
    hit_arr = 0;
    hit_slot = 0;
    for (a = 0; a < arrays_in_use; a++) begin
      for (s = 0; s < SLOTS; s++) begin
        if (!free_map[a][s] && slot_tex[a*SLOTS+s] == id) begin
          hit_arr = a;
          hit_slot = s;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Applies one request to the mirror and returns the result it should give.
  function automatic alloc_result_t alloc_predict(input logic [1:0] op, input id_t id);
    alloc_result_t r;
    int a;
    int s;
    int ha;
    int hs;
    bit hit;
    r = '0;
    hit = locate(id, ha, hs);
    if (op == OP_INSERT) begin
      if (hit) begin
        r.status = STAT_FOUND;
        r.arr = 2'(ha);
        r.slot = 5'(hs);
      end else begin
        a = 0;
        while (a < arrays_in_use && free_map[a] == '0) a++;
        if (a >= arrays_in_use && arrays_in_use < ARRAYS) begin
          // Every open array is full, so the next one is opened.
          a = arrays_in_use;
          free_map[a] = '1;
          arrays_in_use++;
        end
        if (a >= arrays_in_use) begin
          r.status = STAT_FULL;
        end else begin
          s = 0;
          while (!free_map[a][s]) s++;
          slot_tex[a*SLOTS+s] = id;
          free_map[a][s] = 1'b0;
          r.status = STAT_NEW;
          r.arr = 2'(a);
          r.slot = 5'(s);
        end
      end
    end else if (!hit) begin
      r.status = STAT_NOT_FOUND;
    end else begin
      if (op == OP_REMOVE) begin
        free_map[ha][hs] = 1'b1;
      end
      r.status = STAT_FOUND;
      r.arr = 2'(ha);
      r.slot = 5'(hs);
    end
    r.opened = 3'(arrays_in_use);
    return r;
  endfunction

  // An id that is currently mapped, where one can be found quickly.
  function automatic id_t mapped_id();
    int a;
    int s;
    int tries;
    for (tries = 0; tries < 8; tries++) begin
      a = $urandom_range(0, arrays_in_use - 1);
      s = $urandom_range(0, SLOTS - 1);
      if (!free_map[a][s]) return slot_tex[a*SLOTS+s];
    end
    return recent_tex[$urandom_range(0, 63)];
  endfunction

  function automatic id_t pick_id(input int fresh_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < fresh_pct) begin
      if ($urandom_range(0, 15) == 0) return ($urandom_range(0, 1) != 0) ? '1 : '0;
      return id_t'($urandom());
    end
    if (r[0]) return mapped_id();
    return recent_tex[$urandom_range(0, 63)];
  endfunction

  function automatic logic [1:0] pick_op(input int ins_pct, input int rem_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return OP_INSERT;
    if (r < ins_pct + rem_pct) return OP_REMOVE;
    if (r >= 96) return OP_SPARE;
    return OP_LOOKUP;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             results_checked);
    mismatches++;
  endtask

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input logic [1:0] op, input id_t id, input bit typed,
                              input alloc_result_t want);
    alloc_result_t pred;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= id;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = alloc_predict(op, id);
    pending_results.push_back(typed ? want : pred);
    requests_sent++;
    if (pred.status == STAT_FULL) full_replies++;
    if (op == OP_INSERT) begin
      recent_tex[recent_wr] = id;
      recent_wr = (recent_wr + 1) % 64;
    end
  endtask

  // A burst of idle cycles on the request side, now and then.
  task automatic sender_gap();
    if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int ins_pct, input int rem_pct,
                           input int fresh_pct);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        gaps_on = $urandom_range(0, 2) != 0;
        stalls_on = $urandom_range(0, 2) != 0;
      end
      sender_gap();
      send_request(pick_op(ins_pct, rem_pct), pick_id(fresh_pct), 1'b0, '0);
    end
  endtask

  // Stimulus: directed table, then random phases that fill, churn and drain the store.
  initial begin
    for (int a = 0; a < ARRAYS; a++) free_map[a] = '1;
    arrays_in_use = 1;
    for (int i = 0; i < 64; i++) recent_tex[i] = '0;
    recent_wr = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    quiet = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      sender_gap();
      send_request(dir_rows[i].op, dir_rows[i].id, dir_rows[i].typed, dir_rows[i].want);
    end
    wait_for_results();
    run_phase(260, 85, 3, 85);
    wait_for_results();
    run_phase(280, 40, 30, 40);
    run_phase(180, 10, 75, 15);
    quiet = 1'b1;
    run_phase(80, 40, 30, 40);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests over all four operation codes and checked %0d results;",
             requests_sent, results_checked);
    $display("%0d inserts met a full store, %0d arrays were open at the end.",
             full_replies, arrays_in_use);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side ready, with stall bursts except in the final stretch.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!rst && stalls_on && !quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 14) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", m_tuser, 0);
      end else begin
        head = pending_results.pop_front();
        if (m_tuser != head.status) report_mismatch("status", m_tuser, head.status);
        if (m_tdata[1:0] != head.arr) report_mismatch("array_index", m_tdata[1:0], head.arr);
        if (m_tdata[6:2] != head.slot) report_mismatch("slot_index", m_tdata[6:2], head.slot);
        if (m_tdata[9:7] != head.opened)
          report_mismatch("arrays_open", m_tdata[9:7], head.opened);
        if (m_tdata[15:10] != '0) report_mismatch("tdata padding", m_tdata[15:10], 0);
      end
    end
  end

  // Ends the run if neither side moves anything for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out with %0d results outstanding.", pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches = 0;
    requests_sent = 0;
    results_checked = 0;
    full_replies = 0;
    idle_cycles = 0;
    stall_left = 0;
  end

endmodule
